### sv/bvam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvam_pkg: shared types and constants of the battery voltage average monitor
// Window geometry, derived datapath widths, register indexes, the controller
// state type and the command and status bundles.
// ----------------------------------------------------------------------------
package bvam_pkg;

	// Window geometry
	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 10;

	// Port widths fixed by the interface
	localparam int ADC_W        = 10;
	localparam int VOLT_W       = 16;
	localparam int USED_W       = 4;
	localparam int GAIN_W       = 24;
	localparam int THRESH_W     = 16;
	localparam int CFG_INDEX_W  = 4;
	localparam int CFG_DATA_W   = 24;
	localparam int GAIN_FRAC_W  = 16;

	// Derived datapath widths
	localparam int SUM_MAX  = WINDOW * ((1 << SAMPLE_BITS) - 1);
	localparam int SUM_W    = $clog2(SUM_MAX + 1);
	localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int COUNT_W  = $clog2(WINDOW + 1);
	localparam int PROD_W   = SUM_W + GAIN_W;
	localparam int QUOT_W   = PROD_W - GAIN_FRAC_W;
	localparam int STEP_W   = $clog2(QUOT_W + 1);

	// Register reset values
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(96095);
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(600);

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESH = CFG_INDEX_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MULT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;   // capture sample, read oldest ring entry
		logic update;    // write ring, adjust sum, advance position
		logic mult;      // scale sum by gain, start divider
		logic div_step;  // one quotient bit
		logic load_out;  // fill output register
	} cmd_t;

	typedef struct packed {
		logic div_last;  // current step produces the final quotient bit
	} sts_t;

endpackage
`default_nettype wire

### sv/bvam_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvam_ctrl: sequencing controller
// Steps one sample through ring update, gain multiply and serial divide, and
// owns the input stall and the output valid flag.
// ----------------------------------------------------------------------------
module bvam_ctrl
	import bvam_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire  out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Hold output valid until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

	// An accepted beat starts the ring update
	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_UPDATE))
		else $error("accepted beat did not start update");

	// A new result appears only after the divider finished
	a_valid_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output valid without finished division");

	// The last divide step is flagged only while dividing
	a_last_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_last |-> (state_q == ST_DIV))
		else $error("divider finish flagged outside divide state");

endmodule
`default_nettype wire

### sv/bvam_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvam_datapath: ring, running sum, gain multiply and serial divider
// Holds the configuration registers, the sample ring memory, the running sum,
// a restoring divider by the sample count and the output payload register.
// ----------------------------------------------------------------------------
module bvam_datapath
	import bvam_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  wire  [ADC_W-1:0]        adc_sample,
	input  wire                     cfg_we,
	input  wire  [CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0]   cfg_data,
	output logic [VOLT_W-1:0]       voltage_centi,
	output logic                    undervoltage,
	output logic [USED_W-1:0]       samples_used
);

	logic [GAIN_W-1:0]      gain_q;
	logic [THRESH_W-1:0]    thresh_q;
	logic [SAMPLE_BITS-1:0] ring [WINDOW];
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] old_q;
	logic [POS_W-1:0]       pos_q;
	logic                   full_q;
	logic [SUM_W-1:0]       sum_q;
	logic [COUNT_W-1:0]     count;
	logic [PROD_W-1:0]      prod;
	logic [QUOT_W-1:0]      dvd_q;
	logic [COUNT_W-1:0]     rem_q;
	logic [COUNT_W:0]       trial;
	logic                   qbit;
	logic [STEP_W-1:0]      step_q;
	logic [VOLT_W-1:0]      volt_sat;
	logic [VOLT_W-1:0]      volt_q;
	logic                   uv_q;
	logic [USED_W-1:0]      used_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_GAIN) begin
				gain_q <= cfg_data[GAIN_W-1:0];
			end else if (cfg_index == CFG_THRESH) begin
				thresh_q <= cfg_data[THRESH_W-1:0];
			end
		end
	end

	// Ring memory: read oldest entry on accept, write new sample on update
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= SAMPLE_BITS'(adc_sample);
			old_q    <= ring[pos_q];
		end
		if (cmd.update) begin
			ring[pos_q] <= sample_q;
		end
	end

	// Running sum, write position and fill flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_q - (full_q ? SUM_W'(old_q) : SUM_W'(0)) + SUM_W'(sample_q);
			if (pos_q == POS_W'(WINDOW - 1)) begin
				pos_q  <= '0;
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// Samples in the average
	assign count = full_q ? COUNT_W'(WINDOW) : COUNT_W'(pos_q);

	// Scale by gain, drop the fraction bits
	assign prod = PROD_W'(sum_q) * PROD_W'(gain_q);

	// Restoring divider: one quotient bit per step
	assign trial = {rem_q, dvd_q[QUOT_W-1]};
	assign qbit  = (trial >= {1'b0, count});

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			dvd_q <= prod[PROD_W-1:GAIN_FRAC_W];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[QUOT_W-2:0], qbit};
			if (qbit) begin
				rem_q <= COUNT_W'(trial - {1'b0, count});
			end else begin
				rem_q <= trial[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.mult) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign sts.div_last = (step_q == STEP_W'(QUOT_W - 1));

	// Saturate the quotient to 16 bits
	assign volt_sat = (|dvd_q[QUOT_W-1:VOLT_W]) ? '1 : dvd_q[VOLT_W-1:0];

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			volt_q <= volt_sat;
			uv_q   <= (volt_sat < thresh_q);
			used_q <= USED_W'(count);
		end
	end

	assign voltage_centi = volt_q;
	assign undervoltage  = uv_q;
	assign samples_used  = used_q;

endmodule
`default_nettype wire

### sv/battery_voltage_average_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_average_monitor: moving average with undervoltage trip
// Averages the last ten converter samples (fewer while warming up), scales
// the average to centivolts with a Q16 gain and flags readings below a trip
// threshold.
//
//   channel | handshake              | beat contents
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_stall    | adc_sample
//   out     | out_valid / out_stall  | voltage_centi, undervoltage,
//           |                        | samples_used
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each sample is accepted, written to the ring, scaled by the gain, run through
// the restoring divider by the sample count, one quotient bit a cycle, and
// then loaded into the output register.
// in_stall is low only while the sequencer waits for a new sample; a waiting
// result in the output register does not block acceptance of the next one.
// A finished result waits in the divider until the output register is free.
// Reset clears the sum, position and fill flag and loads register defaults;
// no clearing pass is needed. cfg_ready is always high.
// ----------------------------------------------------------------------------
module battery_voltage_average_monitor
	import bvam_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  [ADC_W-1:0]        adc_sample,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [VOLT_W-1:0]       voltage_centi,
	output logic                    undervoltage,
	output logic [USED_W-1:0]       samples_used,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0]   cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Registers accept a write every cycle
	assign cfg_ready = 1'b1;

	bvam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bvam_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.adc_sample    (adc_sample),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.voltage_centi (voltage_centi),
		.undervoltage  (undervoltage),
		.samples_used  (samples_used)
	);

endmodule
`default_nettype wire

### bench/battery_voltage_average_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_average_monitor_tb: self-checking bench for the monitor
// Feeds converter samples through the in channel and programs gain and trip
// level over the cfg channel. Every accepted sample runs through a local
// copy of the window, sum and scaling, and each accepted output beat is
// compared field by field against the oldest predicted reading. Both sides
// idle and stall at random; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module battery_voltage_average_monitor_tb;
	import bvam_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 148;
	localparam int RANDOM_PHASES  = 8;
	localparam int DRAIN_CYCLES   = 50;

	typedef struct packed {
		logic [VOLT_W-1:0] volt;
		logic              under;
		logic [USED_W-1:0] used;
	} reading_t;

	// Window model and queue of predicted readings
	class reading_scoreboard;
		int unsigned       window_ring[WINDOW];
		int unsigned       next_slot;
		bit                window_full;
		int unsigned       window_sum;
		logic [GAIN_W-1:0]   gain;
		logic [THRESH_W-1:0] trip_level;
		reading_t          expected_readings[$];
		int unsigned       errors;

		function new();
			next_slot   = 0;
			window_full = 0;
			window_sum  = 0;
			gain        = GAIN_RESET;
			trip_level  = THRESH_RESET;
			errors      = 0;
		endfunction

		function void note_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_GAIN)
				gain = data[GAIN_W-1:0];
			else if (index == CFG_THRESH)
				trip_level = data[THRESH_W-1:0];
		endfunction

		function int unsigned pending();
			return expected_readings.size();
		endfunction

		// Advance the window by one sample and predict its reading
		function void note_sample(logic [ADC_W-1:0] adc);
			reading_t        r;
			int unsigned     count;
			longint unsigned product;
			longint unsigned divisor;
			longint unsigned quotient;
			if (window_full)
				window_sum -= window_ring[next_slot];
			window_ring[next_slot] = adc;
			window_sum += adc;
			next_slot++;
			if (next_slot == WINDOW) begin
				next_slot   = 0;
				window_full = 1;
			end
			count    = window_full ? WINDOW : next_slot;
			product  = window_sum;
			product  = product * gain;
			divisor  = count;
			divisor  = divisor << GAIN_FRAC_W;
			quotient = product / divisor;
			if (quotient > 65535)
				quotient = 65535;
			r.volt  = quotient[VOLT_W-1:0];
			r.under = (quotient < trip_level);
			r.used  = count[USED_W-1:0];
			expected_readings.push_back(r);
		endfunction

		// Compare one output beat with the oldest prediction
		function void check_reading(logic [VOLT_W-1:0] volt, logic under,
				logic [USED_W-1:0] used);
			reading_t want;
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected beat voltage_centi %0d undervoltage %0b samples_used %0d",
					$time, volt, under, used);
				errors++;
				return;
			end
			want = expected_readings.pop_front();
			if (volt !== want.volt) begin
				$display("%0t: voltage_centi expected %0d actual %0d", $time, want.volt, volt);
				errors++;
			end
			if (under !== want.under) begin
				$display("%0t: undervoltage expected %0b actual %0b", $time, want.under, under);
				errors++;
			end
			if (used !== want.used) begin
				$display("%0t: samples_used expected %0d actual %0d", $time, want.used, used);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [ADC_W-1:0]       adc_sample;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [VOLT_W-1:0]      voltage_centi;
	logic                   undervoltage;
	logic [USED_W-1:0]      samples_used;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	reading_scoreboard sb;
	bit                no_idle = 1'b0;
	int unsigned       stall_hold = 0;
	int unsigned       stall_roll;
	int unsigned       quiet_cycles = 0;

	battery_voltage_average_monitor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.adc_sample    (adc_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.voltage_centi (voltage_centi),
		.undervoltage  (undervoltage),
		.samples_used  (samples_used),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one sample, hold it until accepted
	task automatic send_sample(input logic [ADC_W-1:0] adc);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		adc_sample <= adc;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_sample(adc);
	endtask

	// Drop input valid and wait for every predicted reading to come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.note_write(index, data);
	endtask

	// Reprogram both registers on an idle block, optionally with a stray index
	task automatic configure(input logic [GAIN_W-1:0] gain, input logic [THRESH_W-1:0] trip,
			input bit stray);
		logic [CFG_DATA_W-1:0] trip_word;
		drain();
		if (stray)
			write_register(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
		write_register(CFG_GAIN, gain);
		trip_word = {8'($urandom), trip};
		write_register(CFG_THRESH, trip_word);
		cfg_valid <= 1'b0;
	endtask

	// Output stall pattern: runs and stalls of random length
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold = stall_hold - 1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 60) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(0, 5);
			end else if (stall_roll < 90) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(8, 40);
			end
		end
	end

	// Check output beats and watch for a stuck run
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall === 1'b0)
				sb.check_reading(voltage_centi, undervoltage, samples_used);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned       phase;
		int unsigned       n;
		int                level;
		int                value;
		int unsigned       roll;
		longint            nominal;
		longint            trip_pick;
		logic [GAIN_W-1:0] gain;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		adc_sample = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Warm-up from one to a full window and on past the wrap, default registers
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd1023);
		send_sample(10'd512);
		send_sample(10'd341);
		send_sample(10'd682);
		send_sample(10'd1);
		send_sample(10'd1022);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd1023);
		send_sample(10'd0);

		// Largest gain: the quotient saturates, trip compare on the clipped value
		configure(24'hFFFFFF, 16'hFFFF, 1'b0);
		send_sample(10'd1023);
		send_sample(10'd1023);
		send_sample(10'd1023);

		// Zero gain trips on any nonzero level, never on level zero
		configure(24'd0, 16'd1, 1'b1);
		send_sample(10'd700);
		send_sample(10'd5);
		configure(24'd0, 16'd0, 1'b0);
		send_sample(10'd1023);

		// Unity gain with a stray register index written first
		configure(24'd65536, 16'd512, 1'b1);
		send_sample(10'd512);
		send_sample(10'd511);
		send_sample(10'd513);
		send_sample(10'd1023);
		send_sample(10'd0);

		// Random phases, each with its own gain and trip level
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: gain = GAIN_RESET;
				1: gain = 24'hFFFFFF;
				2: gain = GAIN_W'($urandom);
				3: gain = GAIN_W'($urandom_range(50000, 150000));
				4: gain = 24'd0;
				5: gain = GAIN_W'($urandom);
				6: gain = 24'd1;
				default: gain = GAIN_W'($urandom_range(80000, 120000));
			endcase
			level   = $urandom_range(0, 1023);
			nominal = (longint'(level) * longint'(gain)) >>> GAIN_FRAC_W;
			case (phase % 3)
				0: trip_pick = nominal + longint'($urandom_range(0, 64)) - 32;
				1: trip_pick = $urandom_range(0, 65535);
				default: trip_pick = (phase % 2 == 0) ? 0 : 65535;
			endcase
			if (trip_pick < 0)
				trip_pick = 0;
			if (trip_pick > 65535)
				trip_pick = 65535;
			configure(gain, THRESH_W'(trip_pick), phase % 2 == 1);
			no_idle = (phase == 3 || phase == 6);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					value = level + int'($urandom_range(0, 16)) - 8;
				end else if (roll < 85) begin
					value = $urandom_range(0, 1023);
				end else begin
					value = ($urandom_range(0, 1) != 0) ? 1023 : 0;
				end
				if (value < 0)
					value = 0;
				if (value > 1023)
					value = 1023;
				send_sample(ADC_W'(value));
				// let the level drift the way a battery does
				if ($urandom_range(0, 9) == 0)
					level = level + int'($urandom_range(0, 2)) - 1;
			end
			no_idle = 1'b0;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected readings never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
